[rtl/core/euler_perspective_project_unit_macros.svh]
// Assertion macros shared by the projection unit RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef EULER_PERSPECTIVE_PROJECT_UNIT_MACROS_SVH
`define EULER_PERSPECTIVE_PROJECT_UNIT_MACROS_SVH

// Check cons in the same cycle as ante (cons may open with a ## delay)
`define EPP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Check cons starting in the cycle after ante
`define EPP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

[rtl/core/epp_pkg.sv]
// Shared types and constants of the perspective projection unit.
// No dependencies; every module of the unit imports it.
package epp_pkg;

    // Field widths
    localparam int COORD_W = 32;
    localparam int ANG_W   = 16;
    localparam int SIN_W   = 32;
    localparam int DW      = 33;   // world minus camera
    localparam int MW      = 20;   // rotation entry, Q16
    localparam int PW      = 53;   // entry times difference
    localparam int RW      = 56;   // rotated coordinate, 32 fraction bits
    localparam int HALF_W  = 12;
    localparam int INV_W   = 24;
    localparam int FOC_W   = 36;

    // Pipeline depths
    localparam int SC_LAT  = 5;
    localparam int MX_LAT  = 3;
    localparam int D_DLY   = SC_LAT + MX_LAT;
    localparam int FRONT   = D_DLY + 2;
    localparam int DIV_N   = 42;

    // Polynomial sine coefficients, Q30
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [29:0] SIN_B = 30'd688904866;
    localparam logic [26:0] SIN_C = 27'd76016977;
    localparam logic [ANG_W-1:0] QUARTER = 16'h4000;

    // Configuration register indexes
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 24;
    localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_INV_TAN_FOV   = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] camera_x;
        logic signed [COORD_W-1:0] camera_y;
        logic signed [COORD_W-1:0] camera_z;
        logic        [ANG_W-1:0]   angle_x;
        logic        [ANG_W-1:0]   angle_y;
        logic        [ANG_W-1:0]   angle_z;
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic                      visible;
        logic                      depth_zero;
    } res_word_t;

endpackage

[rtl/core/epp_sincos.sv]
// Five-stage polynomial sine and cosine of one binary angle.
// Depends on epp_pkg for widths and coefficients.
module epp_sincos
    import epp_pkg::*;
(
    input  logic                    clk,
    input  logic [ANG_W-1:0]        angle,
    output logic signed [SIN_W-1:0] sin_q,
    output logic signed [SIN_W-1:0] cos_q
);

    logic [ANG_W-1:0]        lane_ang [2];
    logic [14:0]             f1_reg   [2];
    logic [14:0]             f2_reg   [2];
    logic [14:0]             f3_reg   [2];
    logic                    neg1_reg [2];
    logic                    neg2_reg [2];
    logic                    neg3_reg [2];
    logic                    neg4_reg [2];
    logic [30:0]             z2a_reg  [2];
    logic [30:0]             z2b_reg  [2];
    logic [27:0]             u_reg    [2];
    logic [30:0]             v_reg    [2];
    logic [31:0]             s_reg    [2];
    logic signed [SIN_W-1:0] out_reg  [2];

    // Lane 0 is the sine, lane 1 the sine a quarter turn ahead
    assign lane_ang[0] = angle;
    assign lane_ang[1] = angle + QUARTER;

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic [14:0] f_next;
        logic [29:0] sq;
        logic [57:0] pc;
        logic [29:0] t;
        logic [60:0] pt;
        logic [30:0] t2;
        logic [45:0] ps;

        // Fold the angle into the first quadrant
        always_comb
        begin
            if (lane_ang[g][14])
                f_next = 15'h4000 - {1'b0, lane_ang[g][13:0]};
            else
                f_next = {1'b0, lane_ang[g][13:0]};
        end

        assign sq = 30'(f_next) * 30'(f_next);
        assign pc = 58'(z2a_reg[g]) * 58'(SIN_C);
        assign t  = SIN_B - {2'b00, u_reg[g]};
        assign pt = 61'(z2b_reg[g]) * 61'(t);
        assign t2 = SIN_A - v_reg[g];
        assign ps = 46'(f3_reg[g]) * 46'(t2);

        // Advance the polynomial one product per stage
        always_ff @(posedge clk)
        begin
            f1_reg[g]   <= f_next;
            neg1_reg[g] <= lane_ang[g][15];
            z2a_reg[g]  <= {sq[28:0], 2'b00};

            f2_reg[g]   <= f1_reg[g];
            neg2_reg[g] <= neg1_reg[g];
            z2b_reg[g]  <= z2a_reg[g];
            u_reg[g]    <= pc[57:30];

            f3_reg[g]   <= f2_reg[g];
            neg3_reg[g] <= neg2_reg[g];
            v_reg[g]    <= pt[60:30];

            neg4_reg[g] <= neg3_reg[g];
            s_reg[g]    <= ps[45:14];

            out_reg[g]  <= neg4_reg[g] ? -$signed(s_reg[g]) : $signed(s_reg[g]);
        end
    end

    assign sin_q = out_reg[0];
    assign cos_q = out_reg[1];

endmodule

[rtl/core/epp_matrix.sv]
// Three-stage build of the Z-X-Y rotation matrix, entries reduced to Q16.
// Depends on epp_pkg; fed by three epp_sincos instances.
module epp_matrix
    import epp_pkg::*;
(
    input  logic                    clk,
    input  logic signed [SIN_W-1:0] sx,
    input  logic signed [SIN_W-1:0] cx,
    input  logic signed [SIN_W-1:0] sy,
    input  logic signed [SIN_W-1:0] cy,
    input  logic signed [SIN_W-1:0] sz,
    input  logic signed [SIN_W-1:0] cz,
    output logic signed [MW-1:0]    m [9]
);

    localparam int Q1W = 34;
    localparam int EW  = 35;

    function automatic logic signed [Q1W-1:0] qmul_a(input logic signed [SIN_W-1:0] a,
                                                     input logic signed [SIN_W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return $signed(p[63:30]);
    endfunction

    function automatic logic signed [Q1W-1:0] qmul_b(input logic signed [Q1W-1:0] a,
                                                     input logic signed [SIN_W-1:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return $signed(p[63:30]);
    endfunction

    logic signed [Q1W-1:0] czcy_reg, szsx_reg, cxsz_reg, czsy_reg, cysz_reg;
    logic signed [Q1W-1:0] czsx_reg, czcx_reg, szsy_reg, cxsy_reg, cxcy_reg;
    logic signed [SIN_W-1:0] sx1_reg, sy1_reg, sx2_reg;
    logic signed [Q1W-1:0] czcy2_reg, cxsz2_reg, czsy2_reg, cysz2_reg;
    logic signed [Q1W-1:0] czcx2_reg, szsy2_reg, cxsy2_reg, cxcy2_reg;
    logic signed [Q1W-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [EW-1:0]  e [9];
    logic signed [MW-1:0]  m_reg [9];

    // Form the pair products
    always_ff @(posedge clk)
    begin
        czcy_reg <= qmul_a(cz, cy);
        szsx_reg <= qmul_a(sz, sx);
        cxsz_reg <= qmul_a(cx, sz);
        czsy_reg <= qmul_a(cz, sy);
        cysz_reg <= qmul_a(cy, sz);
        czsx_reg <= qmul_a(cz, sx);
        czcx_reg <= qmul_a(cz, cx);
        szsy_reg <= qmul_a(sz, sy);
        cxsy_reg <= qmul_a(cx, sy);
        cxcy_reg <= qmul_a(cx, cy);
        sx1_reg  <= sx;
        sy1_reg  <= sy;
    end

    // Form the triple products, hold the pairs
    always_ff @(posedge clk)
    begin
        t1_reg    <= qmul_b(szsx_reg, sy1_reg);
        t2_reg    <= qmul_b(cysz_reg, sx1_reg);
        t3_reg    <= qmul_b(czsx_reg, sy1_reg);
        t4_reg    <= qmul_b(czcy_reg, sx1_reg);
        czcy2_reg <= czcy_reg;
        cxsz2_reg <= cxsz_reg;
        czsy2_reg <= czsy_reg;
        cysz2_reg <= cysz_reg;
        czcx2_reg <= czcx_reg;
        szsy2_reg <= szsy_reg;
        cxsy2_reg <= cxsy_reg;
        cxcy2_reg <= cxcy_reg;
        sx2_reg   <= sx1_reg;
    end

    // Combine into entries, still Q30
    always_comb
    begin
        e[0] = EW'(czcy2_reg) - EW'(t1_reg);
        e[1] = -EW'(cxsz2_reg);
        e[2] = EW'(czsy2_reg) + EW'(t2_reg);
        e[3] = EW'(cysz2_reg) + EW'(t3_reg);
        e[4] = EW'(czcx2_reg);
        e[5] = EW'(szsy2_reg) - EW'(t4_reg);
        e[6] = -EW'(cxsy2_reg);
        e[7] = EW'(sx2_reg);
        e[8] = EW'(cxcy2_reg);
    end

    // Drop to Q16 with a floor shift
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
            m_reg[i] <= $signed(e[i][MW+13:14]);
    end

    assign m = m_reg;

endmodule

[rtl/core/epp_project.sv]
// Perspective divide: magnitudes, numerator products, pipelined restoring
// divide and output saturation. Depends on epp_pkg and the assertion macros.
`include "euler_perspective_project_unit_macros.svh"
module epp_project
    import epp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vld_in,
    input  logic signed [RW-1:0] r_x,
    input  logic signed [RW-1:0] r_y,
    input  logic signed [RW-1:0] r_z,
    input  logic [HALF_W-1:0]    half_w,
    input  logic [HALF_W-1:0]    half_h,
    input  logic [INV_W-1:0]     inv_fov,
    output logic                 res_strobe,
    output res_word_t            res
);

    localparam int AW  = RW;
    localparam int FH  = FOC_W / 2;
    localparam int AH  = AW / 2;
    localparam int PPW = FH + AH;
    localparam int NW  = FOC_W + AW;
    localparam int QW  = DIV_N;
    localparam int HW  = NW - QW;
    localparam logic [QW-1:0] QCLAMP = QW'(64'd1 << 40);

    typedef struct packed {
        logic       zero;
        logic       vis;
        logic [1:0] rneg;
        logic [1:0] qneg;
        logic [1:0] clamp;
    } ctl_t;

    logic [FOC_W-1:0] focal_reg;
    logic             vld1_reg, vld2_reg, vld3_reg, strobe_reg;
    logic             dvld_reg [DIV_N+1];
    ctl_t             ctl1_reg, ctl2_reg, ctl3_reg;
    ctl_t             dctl_reg [DIV_N+1];
    logic [AW-1:0]    mag_reg  [2];
    logic [AW-1:0]    dvs1_reg, dvs2_reg, dvs3_reg;
    logic [AW-1:0]    dvs_reg  [DIV_N+1];
    logic [PPW-1:0]   pp_reg   [2][4];
    logic [NW-1:0]    num_reg  [2];
    logic [AW-1:0]    rem_reg  [DIV_N+1][2];
    logic [QW-1:0]    lq_reg   [DIV_N+1][2];
    res_word_t        res_reg;
    logic signed [RW-1:0] rin [2];
    logic [HALF_W-1:0] half [2];
    logic [COORD_W-1:0] sat [2];
    ctl_t             ctl_init;

    // Focal length follows the configuration
    always_ff @(posedge clk)
        focal_reg <= FOC_W'(half_h) * FOC_W'(inv_fov);

    assign rin[0]  = r_x;
    assign rin[1]  = r_y;
    assign half[0] = half_w;
    assign half[1] = half_h;

    // Valid bits through the fixed stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg   <= 1'b0;
            vld2_reg   <= 1'b0;
            vld3_reg   <= 1'b0;
            strobe_reg <= 1'b0;
            for (int k = 0; k <= DIV_N; k++)
                dvld_reg[k] <= 1'b0;
        end
        else
        begin
            vld1_reg    <= vld_in;
            vld2_reg    <= vld1_reg;
            vld3_reg    <= vld2_reg;
            dvld_reg[0] <= vld3_reg;
            for (int k = 1; k <= DIV_N; k++)
                dvld_reg[k] <= dvld_reg[k-1];
            strobe_reg  <= dvld_reg[DIV_N];
        end
    end

    // Take magnitudes and signs
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            mag_reg[l]       <= rin[l][RW-1] ? AW'(-rin[l]) : AW'(rin[l]);
            ctl1_reg.rneg[l] <= rin[l][RW-1];
            ctl1_reg.qneg[l] <= rin[l][RW-1] ^ (r_z > 0);
        end
        dvs1_reg       <= r_z[RW-1] ? AW'(-r_z) : AW'(r_z);
        ctl1_reg.zero  <= (r_z == '0);
        ctl1_reg.vis   <= (r_z > 0);
        ctl1_reg.clamp <= 2'b00;
    end

    // Split focal times magnitude into four partial products
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            pp_reg[l][0] <= PPW'(focal_reg[FH-1:0]) * PPW'(mag_reg[l][AH-1:0]);
            pp_reg[l][1] <= PPW'(focal_reg[FH-1:0]) * PPW'(mag_reg[l][AW-1:AH]);
            pp_reg[l][2] <= PPW'(focal_reg[FOC_W-1:FH]) * PPW'(mag_reg[l][AH-1:0]);
            pp_reg[l][3] <= PPW'(focal_reg[FOC_W-1:FH]) * PPW'(mag_reg[l][AW-1:AH]);
        end
        dvs2_reg <= dvs1_reg;
        ctl2_reg <= ctl1_reg;
    end

    // Sum the partial products into the numerator
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
            num_reg[l] <= NW'(pp_reg[l][0]) + (NW'(pp_reg[l][1]) << AH)
                        + (NW'(pp_reg[l][2]) << FH) + (NW'(pp_reg[l][3]) << (FH + AH));
        dvs3_reg <= dvs2_reg;
        ctl3_reg <= ctl2_reg;
    end

    // Detect an oversized quotient and seed the divider
    always_comb
    begin
        ctl_init = ctl3_reg;
        for (int l = 0; l < 2; l++)
            ctl_init.clamp[l] = AW'(num_reg[l][NW-1:QW]) >= dvs3_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            rem_reg[0][l] <= AW'(num_reg[l][NW-1:QW]);
            lq_reg[0][l]  <= num_reg[l][QW-1:0];
        end
        dvs_reg[0]  <= dvs3_reg;
        dctl_reg[0] <= ctl_init;
    end

    // One quotient bit per stage
    for (genvar k = 1; k <= DIV_N; k++) begin : g_div
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [AW:0] trial;
            logic [AW:0] diff;
            logic        ge;

            assign trial = {rem_reg[k-1][l], lq_reg[k-1][l][QW-1]};
            assign diff  = trial - {1'b0, dvs_reg[k-1]};
            assign ge    = trial >= {1'b0, dvs_reg[k-1]};

            always_ff @(posedge clk)
            begin
                rem_reg[k][l] <= ge ? diff[AW-1:0] : trial[AW-1:0];
                lq_reg[k][l]  <= {lq_reg[k-1][l][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            dvs_reg[k]  <= dvs_reg[k-1];
            dctl_reg[k] <= dctl_reg[k-1];
        end
    end

    // Clamp, sign, add the offset and saturate
    always_comb
    begin
        logic [QW-1:0]      qc;
        logic signed [42:0] sv;
        logic signed [43:0] sum;
        for (int l = 0; l < 2; l++)
        begin
            qc = lq_reg[DIV_N][l];
            if (dctl_reg[DIV_N].clamp[l] || (qc > QCLAMP))
                qc = QCLAMP;
            sv = dctl_reg[DIV_N].qneg[l] ? -$signed(43'(qc)) : $signed(43'(qc));
            sum = 44'(sv) + $signed({16'b0, half[l], 16'b0});
            if (dctl_reg[DIV_N].zero)
                sat[l] = dctl_reg[DIV_N].rneg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else if (sum > 44'sh0_7FFF_FFFF)
                sat[l] = 32'h7FFF_FFFF;
            else if (sum < -44'sh0_8000_0000)
                sat[l] = 32'h8000_0000;
            else
                sat[l] = sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg.screen_x   <= $signed(sat[0]);
        res_reg.screen_y   <= $signed(sat[1]);
        res_reg.visible    <= dctl_reg[DIV_N].vis;
        res_reg.depth_zero <= dctl_reg[DIV_N].zero;
    end

    assign res_strobe = strobe_reg;
    assign res        = res_reg;

    `EPP_ASSERT_NXT(a_latency, vld_in, ##(DIV_N+4) res_strobe, "result strobe late or lost")
    `EPP_ASSERT_IMP(a_zero_clamps, dvld_reg[0] && dctl_reg[0].zero, dctl_reg[0].clamp == 2'b11, "zero depth not clamped")
    `EPP_ASSERT_IMP(a_rem_x, dvld_reg[DIV_N] && !dctl_reg[DIV_N].clamp[0], rem_reg[DIV_N][0] < dvs_reg[DIV_N], "x remainder not below divisor")
    `EPP_ASSERT_IMP(a_vis_zero, res_strobe, !(res.visible && res.depth_zero), "visible with zero depth")

endmodule

[rtl/core/euler_perspective_project_unit.sv]
// Throughput: one word per cycle.
// The front end (sine polynomial 5, matrix 3, rotation 2) and the 42-stage
// restoring divider set the latency; every stage is a plain pipeline register.
// busy stays low: a new word may enter on every cycle and results cannot stall.
// rst_n clears the valid pipeline and loads width 1920, height 1080 and a unit
// inverse half-angle tangent.
module euler_perspective_project_unit
    import epp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  in_word_t          item,
    output logic              result_strobe,
    output res_word_t         result,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    logic [12:0]        width_reg;
    logic [12:0]        height_reg;
    logic [INV_W-1:0]   inv_reg;
    logic               accept;
    logic               vld_reg [FRONT];
    logic signed [DW-1:0] d_reg [D_DLY][3];
    logic signed [SIN_W-1:0] sx, cx, sy, cy, sz, cz;
    logic signed [MW-1:0] m [9];
    logic signed [PW-1:0] prod_reg [9];
    logic signed [RW-1:0] r_reg [3];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1920;
            height_reg <= 13'd1080;
            inv_reg    <= 24'd65536;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata[12:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata[12:0];
                REG_INV_TAN_FOV:   inv_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front-end valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FRONT; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k < FRONT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Form the difference vector (z negated) and hold it beside the matrix
    always_ff @(posedge clk)
    begin
        d_reg[0][0] <= DW'(item.world_x) - DW'(item.camera_x);
        d_reg[0][1] <= DW'(item.world_y) - DW'(item.camera_y);
        d_reg[0][2] <= DW'(item.camera_z) - DW'(item.world_z);
        for (int k = 1; k < D_DLY; k++)
            d_reg[k] <= d_reg[k-1];
    end

    epp_sincos u_sc_x (.clk(clk), .angle(item.angle_x), .sin_q(sx), .cos_q(cx));
    epp_sincos u_sc_y (.clk(clk), .angle(item.angle_y), .sin_q(sy), .cos_q(cy));
    epp_sincos u_sc_z (.clk(clk), .angle(item.angle_z), .sin_q(sz), .cos_q(cz));

    epp_matrix u_matrix (
        .clk(clk),
        .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
        .m(m)
    );

    // Rotate: nine products, then three sums
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                prod_reg[3*i+j] <= PW'(m[3*i+j]) * PW'(d_reg[D_DLY-1][j]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            r_reg[i] <= RW'(prod_reg[3*i]) + RW'(prod_reg[3*i+1]) + RW'(prod_reg[3*i+2]);
    end

    epp_project u_project (
        .clk(clk),
        .rst_n(rst_n),
        .vld_in(vld_reg[FRONT-1]),
        .r_x(r_reg[0]),
        .r_y(r_reg[1]),
        .r_z(r_reg[2]),
        .half_w(width_reg[12:1]),
        .half_h(height_reg[12:1]),
        .inv_fov(inv_reg),
        .res_strobe(result_strobe),
        .res(result)
    );

endmodule
